// File: rtl/dhm_pkg.sv
`default_nettype none
package dhm_pkg;
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned ValueWidthDef = 64;
  localparam int unsigned KeyW = 31;
  localparam int unsigned SizeW = 11;
  localparam int unsigned DivW = 16;
  localparam int unsigned OutSlotW = 10;

  localparam logic [1:0] OpPut = 2'd0;
  localparam logic [1:0] OpErase = 2'd1;
  localparam logic [1:0] OpFind = 2'd2;
  localparam logic [1:0] OpQuery = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDup = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StMiss = 2'd3;

  localparam logic [1:0] SlotNever = 2'd0;
  localparam logic [1:0] SlotOcc = 2'd1;
  localparam logic [1:0] SlotDel = 2'd2;

  localparam logic CfgSize = 1'b0;
  localparam logic CfgDiv = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD1, S_MOD2, S_STEPSUB, S_RD, S_WAIT, S_CHECK,
    S_WRITE, S_RVAL, S_RVWAIT, S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/dhm_ram.sv
`default_nettype none
module dhm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/dhm_modu.sv
`default_nettype none
// restoring remainder, one bit a cycle: 31-bit dividend, 16-bit divisor
module dhm_modu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [30:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      rem
);
  logic [30:0] dvd;
  logic [16:0] acc;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] sh;
  logic [16:0] diff;

  assign sh = {acc[15:0], dvd[30]};
  assign diff = sh - {1'b0, divisor};
  assign rem = acc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        acc  <= '0;
        dvd  <= dividend;
      end else if (busy) begin
        acc <= diff[16] ? sh : diff;
        dvd <= {dvd[29:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/double_hash_open_address_map.sv
`default_nettype none
// Set-up: three 31-step bit-serial remainders through one shared unit (home, second hash,
// step mod n), then per probe a status/key read through registered RAMs (S_RD, S_WAIT,
// S_CHECK), then S_WRITE for a put, or S_RVAL and S_RVWAIT for a value read on a hit,
// before the result word is offered. A vacancy query offers its result the next cycle.
// One word at a time: s_tready is low from acceptance until the result word has been taken.
// Synchronous reset; then a clearing pass over all TableDepth slots marks every slot unused.
module double_hash_open_address_map #(
  parameter int unsigned TableDepth = dhm_pkg::TableDepthDef,
  parameter int unsigned ValueWidth = dhm_pkg::ValueWidthDef
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // operation[1:0], key[32:2], value[96:33], zero pad
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0], home_slot[11:2], slot[21:12], value_res[85:22], free_count[96:86], pad
  output logic [103:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_wdata
);
  import dhm_pkg::*;
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = AW + 1;

  state_t state, state_next;

  logic [SizeW-1:0] table_size;
  logic [DivW-1:0]  step_divisor;
  logic [1:0]       op;
  logic [KeyW-1:0]  key;
  logic [ValueWidth-1:0] val;
  logic [CW-1:0] n, home, idx, stp, pcnt, at, occ;
  logic          have_free;
  logic [1:0]    status;
  logic [ValueWidth-1:0] vres;
  logic [AW-1:0] clr;

  // effective size and divisor
  logic [CW:0] n_full;
  always_comb begin
    if (table_size == '0) n_full = (CW+1)'(1);
    else if ({{(CW+1){1'b0}}, table_size} > (CW+SizeW+1)'(TableDepth)) n_full = (CW+1)'(TableDepth);
    else n_full = (CW+1)'(table_size);
  end
  logic [DivW-1:0] dv;
  assign dv = (step_divisor == '0) ? DivW'(1) : step_divisor;

  // shared remainder unit: key mod n, key mod divisor, then raw step mod n
  logic        m_start, m_done;
  logic [15:0] m_div, m_rem;
  logic [30:0] m_dvd;
  assign m_div = (state == S_MOD1 || state == S_STEPSUB) ? 16'(n) : dv;
  always_comb begin
    if (state == S_IDLE) m_dvd = s_tdata[32:2];
    else if (state == S_MOD2) m_dvd = 31'(dv - m_rem);
    else m_dvd = key;
  end
  dhm_modu u_mod (.clk, .rst, .start(m_start), .dividend(m_dvd), .divisor(m_div),
                  .done(m_done), .rem(m_rem));

  // memories
  logic st_we, kv_we;
  logic [AW-1:0] st_waddr, raddr;
  logic [1:0] st_wdata, st_rd;
  logic [KeyW-1:0] key_rd;
  logic [ValueWidth-1:0] val_rd;
  assign raddr = (state == S_RVAL || state == S_RVWAIT) ? at[AW-1:0] : idx[AW-1:0];
  dhm_ram #(.Width(2), .Depth(TableDepth)) u_st (.clk, .we(st_we), .waddr(st_waddr),
    .wdata(st_wdata), .raddr(raddr), .rdata(st_rd));
  dhm_ram #(.Width(KeyW), .Depth(TableDepth)) u_key (.clk, .we(kv_we), .waddr(at[AW-1:0]),
    .wdata(key), .raddr(raddr), .rdata(key_rd));
  dhm_ram #(.Width(ValueWidth), .Depth(TableDepth)) u_val (.clk, .we(kv_we),
    .waddr(at[AW-1:0]), .wdata(val), .raddr(raddr), .rdata(val_rd));

  // probe index advance: idx + stp mod n, stp already reduced below n
  logic [CW:0] nidx;
  assign nidx = {1'b0, idx} + {1'b0, stp};

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr == AW'(TableDepth - 1)) state_next = S_IDLE;
      S_IDLE:    if (s_tvalid) state_next = (s_tdata[1:0] == OpQuery) ? S_OUT : S_MOD1;
      S_MOD1:    if (m_done) state_next = S_MOD2;
      S_MOD2:    if (m_done) state_next = S_STEPSUB;
      S_STEPSUB: if (m_done) state_next = S_RD;
      S_RD:      state_next = S_WAIT;
      S_WAIT:    state_next = S_CHECK;
      S_CHECK: begin
        if (st_rd == SlotNever ||
            (st_rd == SlotOcc && key_rd == key) || pcnt == n - CW'(1)) begin
          if (op == OpPut) state_next = S_WRITE;
          else if (st_rd == SlotOcc && key_rd == key) state_next = S_RVAL;
          else state_next = S_OUT;
        end else state_next = S_RD;
      end
      S_WRITE:   state_next = S_OUT;
      S_RVAL:    state_next = S_RVWAIT;
      S_RVWAIT:  state_next = S_OUT;
      S_OUT:     if (m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_OUT);
    m_start  = (state == S_IDLE && s_tvalid && s_tdata[1:0] != OpQuery) ||
               (state == S_MOD1 && m_done) || (state == S_MOD2 && m_done);
    st_we    = 1'b0;
    st_waddr = at[AW-1:0];
    st_wdata = SlotOcc;
    kv_we    = 1'b0;
    if (state == S_CLEAR) begin
      st_we = 1'b1; st_waddr = clr; st_wdata = SlotNever;
    end else if (state == S_WRITE && op == OpPut && status == StOk) begin
      st_we = 1'b1; kv_we = 1'b1;
    end else if (state == S_RVAL && op == OpErase) begin
      st_we = 1'b1; st_wdata = SlotDel;
    end
  end

  logic dup_hit, key_hit;
  assign key_hit = (st_rd == SlotOcc) && (key_rd == key);
  assign dup_hit = key_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      occ <= '0;
      table_size <= SizeW'(1024);
      step_divisor <= DivW'(7);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (cfg_we) begin
        if (cfg_index == CfgSize) table_size <= cfg_wdata[SizeW-1:0];
        else step_divisor <= cfg_wdata;
      end
      if (state == S_WRITE && status == StOk) occ <= occ + CW'(1);
      if (state == S_RVAL && op == OpErase && occ != '0) occ <= occ - CW'(1);
    end
    unique case (state)
      S_IDLE: begin
        op <= s_tdata[1:0];
        key <= s_tdata[32:2];
        val <= s_tdata[33 +: ValueWidth];
        n <= n_full[CW-1:0];
        have_free <= 1'b0;
        status <= StOk;
        vres <= '0;
        pcnt <= '0;
        at <= '0;
      end
      S_MOD1: if (m_done) begin home <= CW'(m_rem); idx <= CW'(m_rem); end
      S_STEPSUB: if (m_done) stp <= CW'(m_rem);
      S_CHECK: begin
        if (st_rd == SlotNever) begin
          if (!have_free) begin have_free <= 1'b1; at <= idx; end
        end else if (key_hit) begin
          at <= idx;
        end else if (st_rd == SlotDel && !have_free) begin
          have_free <= 1'b1; at <= idx;
        end
        if (op == OpPut) begin
          if (dup_hit) status <= StDup;
          else if (!have_free && st_rd != SlotNever && st_rd != SlotDel &&
                   (pcnt == n - CW'(1))) status <= StFull;
        end else if (!key_hit && (st_rd == SlotNever || pcnt == n - CW'(1))) status <= StMiss;
        pcnt <= pcnt + CW'(1);
        idx <= (nidx >= {1'b0, n}) ? CW'(nidx - {1'b0, n}) : nidx[CW-1:0];
      end
      S_RVWAIT: vres <= val_rd;
      default: ;
    endcase
  end

  // free count saturates at zero after table_size shrinks
  logic [CW:0] fc;
  assign fc = ({1'b0, n} > {1'b0, occ}) ? {1'b0, n} - {1'b0, occ} : '0;

  logic [63:0] vout;
  assign vout = 64'(vres);
  logic [9:0] home_o, slot_o;
  assign home_o = (op == OpPut) ? 10'(home) : 10'd0;
  assign slot_o = (op == OpPut && status == StOk) ? 10'(at) : 10'd0;
  assign m_tdata = {7'd0, 11'(fc), vout, slot_o, home_o, status};

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(TableDepth)) else $error("occupancy overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: sim/testbench.sv
module testbench;
  import dhm_pkg::*;

  localparam logic [1:0] OpVacancy = 2'd3;  // same code as OpQuery, reports free count only
  localparam int unsigned Depth = 1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] key;
    logic [63:0] val;
  } map_req_t;

  // lowest field last: status sits in the low bits of the word
  typedef struct packed {
    logic [10:0] free;
    logic [63:0] vres;
    logic [9:0]  slot;
    logic [9:0]  home;
    logic [1:0]  status;
  } map_resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CfgSize;
  logic [15:0]  cfg_wdata = '0;

  double_hash_open_address_map uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the table
  logic [1:0]  shadow_state [Depth];
  logic [30:0] shadow_key [Depth];
  logic [63:0] shadow_val [Depth];
  int unsigned shadow_used;
  logic [10:0] shadow_size;
  logic [15:0] shadow_div;

  map_req_t  pending_words [$];
  map_resp_t expected_resp [$];
  int        errors = 0;

  function automatic map_resp_t predict_map_access(map_req_t rq);
    map_resp_t r;
    longint unsigned n, d, step, home, idx, at;
    bit have_free, dup, hit;
    r = '0;
    n = (shadow_size == 0) ? 1 : (shadow_size > Depth) ? Depth : shadow_size;
    d = (shadow_div == 0) ? 1 : shadow_div;
    step = d - (rq.key % d);
    home = rq.key % n;
    have_free = 0; dup = 0; hit = 0; at = 0;
    if (rq.op == OpPut) begin
      r.home = home[9:0];
      for (longint unsigned i = 0; i < n; i++) begin
        idx = (home + i * step) % n;
        if (shadow_state[idx] == SlotNever) begin
          if (!have_free) begin
            have_free = 1; at = idx;
          end
          break;
        end
        if (shadow_state[idx] == SlotOcc && shadow_key[idx] == rq.key) begin
          dup = 1;
          break;
        end
        if (shadow_state[idx] == SlotDel && !have_free) begin
          have_free = 1; at = idx;
        end
      end
      if (dup) r.status = StDup;
      else if (!have_free) r.status = StFull;
      else begin
        shadow_state[at] = SlotOcc;
        shadow_key[at] = rq.key;
        shadow_val[at] = rq.val;
        shadow_used++;
        r.status = StOk;
        r.slot = at[9:0];
      end
    end else if (rq.op == OpErase || rq.op == OpFind) begin
      for (longint unsigned i = 0; i < n; i++) begin
        idx = (home + i * step) % n;
        if (shadow_state[idx] == SlotNever) break;
        if (shadow_state[idx] == SlotOcc && shadow_key[idx] == rq.key) begin
          hit = 1; at = idx;
          break;
        end
      end
      if (hit) begin
        r.status = StOk;
        r.vres = shadow_val[at];
        if (rq.op == OpErase) begin
          shadow_state[at] = SlotDel;
          if (shadow_used > 0) shadow_used--;
        end
      end else r.status = StMiss;
    end
    r.free = (n > shadow_used) ? 11'(n - shadow_used) : 11'd0;
    return r;
  endfunction

  // driver
  map_req_t    cur_word;
  int          in_gap = 0;
  bit          in_calm = 0;
  always @(posedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_resp.push_back(predict_map_access(cur_word));
        nv = 1'b0;
        if ($urandom_range(0, 99) < 4) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 9);
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tdata <= {7'b0, cur_word.val, cur_word.key, cur_word.op};
          nv = 1'b1;
        end
      end
    end
    s_tvalid <= nv;
  end

  // monitor
  int out_stall = 0;
  bit out_calm = 0;
  always @(posedge clk) begin
    map_resp_t got, want;
    logic nr;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[96:0];
        if (expected_resp.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = expected_resp.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.home !== want.home) begin
            $display("%0t: home_slot exp %0d got %0d", $time, want.home, got.home);
            errors++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
            errors++;
          end
          if (got.vres !== want.vres) begin
            $display("%0t: value_res exp %h got %h", $time, want.vres, got.vres);
            errors++;
          end
          if (got.free !== want.free) begin
            $display("%0t: free_count exp %0d got %0d", $time, want.free, got.free);
            errors++;
          end
        end
        if ($urandom_range(0, 99) < 4) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 9);
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      nr = 1'b0;
    end else nr = 1'b1;
    m_tready <= nr;
  end

  task automatic push_word(logic [1:0] op, logic [30:0] key, logic [63:0] val);
    map_req_t rq;
    rq.op = op; rq.key = key; rq.val = val;
    pending_words.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_tvalid || expected_resp.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgSize) shadow_size = data[10:0];
    else shadow_div = data;
  endtask

  function automatic logic [63:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  int unsigned phase_size [8] = '{2047, 7, 31, 4, 0, 1024, 100, 13};
  int unsigned phase_div [8] = '{65535, 3, 1, 5, 0, 13, 97, 7};

  initial begin
    logic [30:0] pool [24];
    int unsigned n, pick;
    logic [1:0] op;
    logic [30:0] key;
    for (int i = 0; i < Depth; i++) shadow_state[i] = SlotNever;
    shadow_used = 0;
    shadow_size = 11'd1024;
    shadow_div = 16'd7;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default settings: extremes, duplicates, reuse of a deleted slot
    push_word(OpPut, 31'd0, 64'd0);
    push_word(OpPut, 31'h7FFFFFFF, '1);
    push_word(OpPut, 31'd0, 64'h5555_5555_5555_5555);
    push_word(OpFind, 31'h7FFFFFFF, 64'd0);
    push_word(OpFind, 31'd5, '1);
    push_word(OpErase, 31'd0, 64'd0);
    push_word(OpErase, 31'd0, 64'd0);
    push_word(OpVacancy, 31'd9, '1);
    push_word(OpPut, 31'd7, 64'hAAAA_AAAA_AAAA_AAAA);
    push_word(OpPut, 31'd1031, 64'h1234_5678_9ABC_DEF0);
    push_word(OpFind, 31'd1031, 64'd0);
    push_word(OpErase, 31'd7, 64'd0);
    push_word(OpPut, 31'd1031, 64'd1);
    push_word(OpPut, 31'd7, 64'd2);
    wait_drained();

    // single slot: full table, then reuse after erase
    write_reg(CfgSize, 16'd1);
    @(posedge clk);
    push_word(OpPut, 31'd3, 64'd33);
    push_word(OpPut, 31'd4, 64'd44);
    push_word(OpFind, 31'd4, 64'd0);
    push_word(OpErase, 31'd3, 64'd0);
    push_word(OpPut, 31'd4, 64'd44);
    push_word(OpVacancy, 31'd0, 64'd0);
    wait_drained();

    // random phases; the drop from 31 to 4 slots leaves more entries than slots
    for (int p = 0; p < 8; p++) begin
      write_reg(CfgSize, 16'(phase_size[p]));
      write_reg(CfgDiv, 16'(phase_div[p]));
      @(posedge clk);
      n = (phase_size[p] == 0) ? 1 : (phase_size[p] > Depth) ? Depth : phase_size[p];
      for (int i = 0; i < 24; i++)
        pool[i] = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 * n));
      for (int i = 0; i < 90; i++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OpPut : (pick < 65) ? OpErase : (pick < 95) ? OpFind : OpVacancy;
        key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 23)] : 31'($urandom);
        push_word(op, key, rand_val());
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_resp.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(64'd12 * 64'd15_000_000);
    $display("testbench: errors");
    $finish;
  end
endmodule
